### sv/assert_macros.svh
// Assertion helpers shared by the console modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("console assertion failed");

// Next-cycle implication, checked only while out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("console assertion failed");

`endif

### sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // Fixed field widths.
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 7;
    localparam int CELL_W     = 16;
    localparam int ADDR_OUT_W = 11;
    localparam int OP_W       = 2;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Cell values.
    localparam logic [CELL_W-1:0] CELL_RESET  = 16'h0720;
    localparam logic [CELL_W-1:0] CELL_ERASED = 16'h0020;

    // Configuration register indexes.
    localparam logic CFG_TEXT_ATTRIBUTE = 1'b0;
    localparam logic CFG_CURSOR_ON      = 1'b1;

    // Command kinds produced by the front end.
    typedef enum logic [2:0] {
        CMD_PRINT,
        CMD_BACKSPACE,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_MOVE,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } cmd_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Executor states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_EXEC,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } back_state_t;

endpackage

### sv/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // char_code, target_col, target_row, zero pad
    input  logic [OP_W-1:0]   s_tuser,   // opcode
    input  q_status_t         q_status,
    input  logic              init_busy,
    output logic              push,
    output cmd_t              cmd
);

    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col_in;
    logic [ROW_W-1:0]  row_in;

    assign ch     = s_tdata[7:0];
    assign col_in = s_tdata[14:8];
    assign row_in = s_tdata[19:15];

    // Items are taken whenever the queue has room and the buffer is ready.
    assign s_tready = !q_status.full && !init_busy;
    assign push     = s_tvalid && s_tready;

    // Saturate the coordinates and sort the operation into a command kind.
    always_comb begin
        cmd.ch  = ch;
        cmd.col = (col_in > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col_in;
        cmd.row = (row_in > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row_in;
        unique case (s_tuser)
            OP_PUT: begin
                priority if (ch == CH_BACKSPACE) begin
                    cmd.kind = CMD_BACKSPACE;
                end else if (ch == CH_LINE_FEED) begin
                    cmd.kind = CMD_NEWLINE;
                end else if (ch == CH_RETURN) begin
                    cmd.kind = CMD_RETURN;
                end else begin
                    cmd.kind = CMD_PRINT;
                end
            end
            OP_MOVE:  cmd.kind = CMD_MOVE;
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_READ:  cmd.kind = CMD_READ;
        endcase
    end

endmodule

### sv/tcw_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_queue
    import tcw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t q_status
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))

endmodule

### sv/tcw_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  q_status_t         q_status,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              init_busy,
    input  logic [ATTR_W-1:0] text_attribute,
    input  logic              cursor_on,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata    // cursor_col, cursor_row, cursor_address,
                                         // cell_value, cursor_visible
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [ROW_W-1:0]   top_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      base_reg;
    logic [AW-1:0]      sweep_reg;
    logic [CELL_W-1:0]  rdata_reg;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg;

    logic [CELL_W-1:0]  mem [CELLS];

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               rd_en;
    logic               out_load;

    logic [CELL_W-1:0]  blank_cell;
    logic               at_last_col;
    logic               at_last_row;
    logic               scroll;
    logic               init_last;
    logic               blank_last;
    logic [COL_W-1:0]   col_sel;
    logic [ROW_W-1:0]   row_sel;
    logic [ROW_W:0]     phys_sum;
    logic [ROW_W-1:0]   phys_row;
    logic [ROW_W-1:0]   top_inc;
    logic [CELL_W-1:0]  cell_out;
    logic [ADDR_OUT_W-1:0] cursor_addr;

    assign blank_cell  = {1'b0, text_attribute, CH_SPACE};
    assign at_last_col = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (cur_row_reg == ROW_W'(ROWS - 1));
    assign init_last   = (sweep_reg == AW'(CELLS - 1));
    assign blank_last  = (sweep_reg == AW'(COLUMNS - 1));
    assign top_inc     = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;

    // A line feed, or a wrap, on the bottom row scrolls the ring of rows.
    assign scroll = at_last_row &&
                    ((cmd_reg.kind == CMD_NEWLINE) ||
                     ((cmd_reg.kind == CMD_PRINT) && at_last_col));

    // Logical row to physical row in the ring, then to a cell address.
    assign col_sel  = (cmd_reg.kind == CMD_READ) ? cmd_reg.col : cur_col_reg;
    assign row_sel  = (cmd_reg.kind == CMD_READ) ? cmd_reg.row : cur_row_reg;
    assign phys_sum = {1'b0, row_sel} + {1'b0, top_reg};
    assign phys_row = (phys_sum >= (ROW_W + 1)'(ROWS)) ?
                      ROW_W'(phys_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(phys_sum);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (init_last) state_next = ST_IDLE;
            ST_IDLE:  if (!q_status.empty) state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (cmd_reg.kind == CMD_CLEAR) begin
                    state_next = ST_CLEAR;
                end else if (scroll) begin
                    state_next = ST_BLANK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BLANK: if (blank_last) state_next = ST_DONE;
            ST_CLEAR: if (init_last) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    // Control outputs and memory write port.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blank_cell;
        rd_en     = 1'b0;
        q_pop     = 1'b0;
        out_load  = 1'b0;
        init_busy = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                init_busy = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = CELL_RESET;
            end
            ST_IDLE: q_pop = !q_status.empty;
            ST_ADDR: ;
            ST_EXEC: begin
                if (cmd_reg.kind == CMD_PRINT) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b0, text_attribute, cmd_reg.ch};
                end else if ((cmd_reg.kind == CMD_BACKSPACE) && (cur_col_reg != '0)) begin
                    mem_we    = 1'b1;
                    mem_wdata = CELL_ERASED;
                end
                rd_en = (cmd_reg.kind == CMD_READ);
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + sweep_reg;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
            end
            ST_DONE:  out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // Control registers: state, cursor, ring top, sweep counter, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)) begin
                sweep_reg <= init_last ? '0 : sweep_reg + 1'b1;
            end else if (state_reg == ST_BLANK) begin
                sweep_reg <= blank_last ? '0 : sweep_reg + 1'b1;
            end
            if (state_reg == ST_EXEC) begin
                unique case (cmd_reg.kind)
                    CMD_PRINT, CMD_NEWLINE: begin
                        if ((cmd_reg.kind == CMD_NEWLINE) || at_last_col) begin
                            cur_col_reg <= '0;
                            if (at_last_row) begin
                                top_reg <= top_inc;
                            end else begin
                                cur_row_reg <= cur_row_reg + 1'b1;
                            end
                        end else begin
                            cur_col_reg <= cur_col_reg + 1'b1;
                        end
                    end
                    CMD_BACKSPACE: begin
                        if (cur_col_reg != '0) begin
                            cur_col_reg <= cur_col_reg - 1'b1;
                        end
                    end
                    CMD_RETURN: cur_col_reg <= '0;
                    CMD_MOVE: begin
                        cur_col_reg <= cmd_reg.col;
                        cur_row_reg <= cmd_reg.row;
                    end
                    CMD_CLEAR: begin
                        cur_col_reg <= '0;
                        cur_row_reg <= '0;
                        top_reg     <= '0;
                    end
                    CMD_READ: ;
                    default: ;
                endcase
            end
        end
    end

    // Command capture and address calculation.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= AW'(32'(phys_row) * 32'(COLUMNS) + 32'(col_sel));
            base_reg <= AW'(32'(top_reg) * 32'(COLUMNS));
        end
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // Result register.
    assign cell_out    = (cmd_reg.kind == CMD_READ) ? rdata_reg : '0;
    assign cursor_addr = ADDR_OUT_W'(32'(cur_row_reg) * 32'(COLUMNS) + 32'(cur_col_reg));

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {cursor_on, cell_out, cursor_addr, cur_row_reg, cur_col_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_IMP(a_col_range, aclk, aresetn, 1'b1, cur_col_reg <= COL_W'(COLUMNS - 1))
    `ASSERT_IMP(a_ring_range, aclk, aresetn, 1'b1,
                (cur_row_reg <= ROW_W'(ROWS - 1)) && (top_reg <= ROW_W'(ROWS - 1)))
    `ASSERT_IMP(a_init_no_cmd, aclk, aresetn, state_reg == ST_INIT, q_status.empty)
    `ASSERT_NXT(a_held_result, aclk, aresetn, out_valid_reg && !m_tready,
                out_valid_reg && $stable(out_data_reg))

endmodule

### sv/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Character-cell text console.
// Input channel (s_*): one item is one operation; s_tuser holds the opcode
// (put character, move cursor, clear screen, read cell) and s_tdata holds
// the character and the target column and row. Each item gives exactly one
// result on the output channel (m_*): cursor column, row and linear address,
// the cell read (zero for other operations) and the cursor visible flag.
// Configuration (cfg_*): index 0 sets the text attribute, index 1 the cursor
// enable; the port is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// An ordinary operation passes from the queue to the result register through
// the executor sequence of pop, address, memory access and result load. A
// scroll also blanks the new bottom row (rows live in a ring, so no copy is
// needed); a clear blanks every cell, one cell write per cycle on the single
// memory port.
// After reset the whole buffer is filled with blank cells, one cell a cycle,
// with s_tready low.
// A two-entry command queue keeps accepting items while a result waits in
// the output register; when the receiver stalls the executor holds the
// next result and the queue fills, then s_tready drops.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // char_code, target_col, target_row, zero pad
    input  logic [OP_W-1:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // cursor_col, cursor_row, cursor_address,
                                         // cell_value, cursor_visible
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    logic [ATTR_W-1:0] text_attribute_reg;
    logic              cursor_on_reg;
    q_status_t         q_status;
    logic              init_busy;
    logic              push;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              pop_cmd;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attribute_reg <= ATTR_W'(7);
            cursor_on_reg      <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TEXT_ATTRIBUTE: text_attribute_reg <= cfg_data[ATTR_W-1:0];
                CFG_CURSOR_ON:      cursor_on_reg      <= cfg_data[0];
            endcase
        end
    end

    tcw_front #(
        .COLUMNS (SCREEN_COLUMNS),
        .ROWS    (SCREEN_ROWS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    tcw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    tcw_back #(
        .COLUMNS (SCREEN_COLUMNS),
        .ROWS    (SCREEN_ROWS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_status       (q_status),
        .q_cmd          (pop_cmd),
        .q_pop          (pop),
        .init_busy      (init_busy),
        .text_attribute (text_attribute_reg),
        .cursor_on      (cursor_on_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

### tb/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int N_COLS         = 80;
    localparam int N_ROWS         = 25;
    localparam int N_CELLS        = N_COLS * N_ROWS;
    localparam int RAND_PER_PHASE = 366;
    localparam int N_PHASES       = 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 20000000;
    localparam int PRINT_CAP      = 40;

    // Fields of one result item, in the order they sit in m_tdata.
    typedef struct packed {
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [ADDR_OUT_W-1:0] addr;
        logic [CELL_W-1:0]     cell_val;
        logic                  vis;
    } console_status_t;

    // One row of the directed table; typed rows carry a literal expectation.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  tc;
        logic [ROW_W-1:0]  tr;
        logic              typed;
        console_status_t   want;
    } directed_op_t;

    localparam console_status_t NO_STATUS  = '0;
    localparam console_status_t HOME       = '{7'd0, 5'd0, 11'd0, 16'h0000, 1'b1};
    localparam console_status_t HOME_BLANK = '{7'd0, 5'd0, 11'd0, CELL_RESET, 1'b1};
    localparam console_status_t CORNER     = '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b1};

    // Directed part: reset contents, saturation, wrap with scroll, controls, clear.
    directed_op_t dir_table [24] = '{
        '{OP_READ,  8'h00,        7'd0,   5'd0,  1'b1, HOME_BLANK},
        '{OP_READ,  8'hFF,        7'd127, 5'd31, 1'b1, HOME_BLANK},
        '{OP_MOVE,  8'h00,        7'd127, 5'd31, 1'b1, CORNER},
        '{OP_PUT,   8'h41,        7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_READ,  8'h00,        7'd79,  5'd23, 1'b0, NO_STATUS},
        '{OP_READ,  8'h00,        7'd79,  5'd24, 1'b0, NO_STATUS},
        '{OP_MOVE,  8'h00,        7'd0,   5'd0,  1'b1, HOME},
        '{OP_PUT,   8'hFF,        7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_PUT,   8'h00,        7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_READ,  8'h00,        7'd2,   5'd0,  1'b0, NO_STATUS},
        '{OP_READ,  8'h00,        7'd1,   5'd0,  1'b0, NO_STATUS},
        '{OP_MOVE,  8'h00,        7'd0,   5'd5,  1'b0, NO_STATUS},
        '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_PUT,   8'h78,        7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_PUT,   CH_RETURN,    7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_PUT,   CH_LINE_FEED, 7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_MOVE,  8'h00,        7'd80,  5'd25, 1'b1, CORNER},
        '{OP_PUT,   CH_LINE_FEED, 7'd0,   5'd0,  1'b0, NO_STATUS},
        '{OP_READ,  8'h00,        7'd0,   5'd24, 1'b0, NO_STATUS},
        '{OP_PUT,   8'h7F,        7'd127, 5'd31, 1'b0, NO_STATUS},
        '{OP_CLEAR, 8'h5A,        7'd127, 5'd31, 1'b1, HOME},
        '{OP_READ,  8'h00,        7'd127, 5'd31, 1'b1, HOME_BLANK},
        '{OP_READ,  8'hAA,        7'd5,   5'd2,  1'b0, NO_STATUS}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = OP_PUT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_TEXT_ATTRIBUTE;
    logic [7:0]            cfg_data  = '0;

    // Console state as the block should hold it.
    logic [CELL_W-1:0]     scr_cells [N_CELLS];
    int                    scr_col;
    int                    scr_row;
    logic [ATTR_W-1:0]     scr_attr;
    logic                  scr_vis;

    console_status_t       awaited_status_q [$];
    console_status_t       seen;
    console_status_t       want_r;
    int                    mismatch_count = 0;
    int                    status_seen    = 0;
    int                    cycle_count    = 0;
    int                    gap_pct        = 20;
    bit                    tx_idle_en     = 1'b1;
    bit                    rx_idle_en     = 1'b1;
    bit                    hold_req       = 1'b0;

    text_console_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Line feed: column to zero, next row, or scroll up with a blank bottom row.
    function automatic void next_row();
        int i;
        scr_col = 0;
        if (scr_row < N_ROWS - 1) begin
            scr_row++;
        end else begin
            for (i = 0; i + N_COLS < N_CELLS; i++)
                scr_cells[i] = scr_cells[i + N_COLS];
            for (i = 0; i < N_COLS; i++)
                scr_cells[(N_ROWS - 1) * N_COLS + i] = {1'b0, scr_attr, CH_SPACE};
        end
    endfunction

    // Applies one operation to the console state and returns the status it reports.
    function automatic console_status_t console_execute(logic [OP_W-1:0] op,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [COL_W-1:0] tc,
                                                        logic [ROW_W-1:0] tr);
        console_status_t res;
        int c;
        int r;
        int i;
        c = (tc > N_COLS - 1) ? N_COLS - 1 : int'(tc);
        r = (tr > N_ROWS - 1) ? N_ROWS - 1 : int'(tr);
        res.cell_val = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_BACKSPACE) begin
                    if (scr_col != 0) begin
                        scr_cells[scr_row * N_COLS + scr_col] = CELL_ERASED;
                        scr_col--;
                    end
                end else if (ch == CH_LINE_FEED) begin
                    next_row();
                end else if (ch == CH_RETURN) begin
                    scr_col = 0;
                end else begin
                    scr_cells[scr_row * N_COLS + scr_col] = {1'b0, scr_attr, ch};
                    if (scr_col >= N_COLS - 1)
                        next_row();
                    else
                        scr_col++;
                end
            end
            OP_MOVE: begin
                scr_col = c;
                scr_row = r;
            end
            OP_CLEAR: begin
                for (i = 0; i < N_CELLS; i++)
                    scr_cells[i] = {1'b0, scr_attr, CH_SPACE};
                scr_col = 0;
                scr_row = 0;
            end
            OP_READ: begin
                res.cell_val = scr_cells[r * N_COLS + c];
            end
            default: ;
        endcase
        res.col  = scr_col[COL_W-1:0];
        res.row  = scr_row[ROW_W-1:0];
        res.addr = ADDR_OUT_W'(scr_row * N_COLS + scr_col);
        res.vis  = scr_vis;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: result %0d %s: got 0x%0h, want 0x%0h",
                     $time, status_seen, what, got, exp);
        mismatch_count++;
    endtask

    // Offers one item on the input channel, after an optional gap, and records
    // its expected status once the block takes it. Called and left at a falling edge.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [COL_W-1:0] tc, input logic [ROW_W-1:0] tr,
                           input logic typed, input console_status_t want);
        console_status_t predicted;
        if (tx_idle_en && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, tr, tc, ch};
        do @(posedge aclk); while (!s_tready);
        predicted = console_execute(op, ch, tc, tr);
        awaited_status_q.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // Writes one register; cfg_valid is left high for a following write.
    task automatic write_reg(input logic idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_TEXT_ATTRIBUTE)
            scr_attr = data[ATTR_W-1:0];
        else
            scr_vis = data[0];
        @(negedge aclk);
    endtask

    // Compare each accepted status item with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = {m_tdata[6:0], m_tdata[11:7], m_tdata[22:12], m_tdata[38:23], m_tdata[39]};
            if (awaited_status_q.size() == 0) begin
                report_mismatch("arrived with nothing pending", m_tdata, 0);
            end else begin
                want_r = awaited_status_q.pop_front();
                if (seen.col != want_r.col)
                    report_mismatch("cursor_col", seen.col, want_r.col);
                if (seen.row != want_r.row)
                    report_mismatch("cursor_row", seen.row, want_r.row);
                if (seen.addr != want_r.addr)
                    report_mismatch("cursor_address", seen.addr, want_r.addr);
                if (seen.cell_val != want_r.cell_val)
                    report_mismatch("cell_value", seen.cell_val, want_r.cell_val);
                if (seen.vis != want_r.vis)
                    report_mismatch("cursor_visible", seen.vis, want_r.vis);
            end
            status_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
    initial begin : receiver
        int stall_left = 0;
        int stall_pct  = 15;
        int tick       = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 45;
                endcase
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (rx_idle_en && stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0]        attr_data;
        logic [7:0]        vis_data;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  tc;
        logic [ROW_W-1:0]  tr;
        int                pick;

        for (int i = 0; i < N_CELLS; i++)
            scr_cells[i] = CELL_RESET;
        scr_col  = 0;
        scr_row  = 0;
        scr_attr = 7'd7;
        scr_vis  = 1'b1;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        // The buffer fill after reset holds s_tready low.
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);

        foreach (dir_table[k])
            send_op(dir_table[k].op, dir_table[k].ch, dir_table[k].tc, dir_table[k].tr,
                    dir_table[k].typed, dir_table[k].want);

        for (int ph = 1; ph <= N_PHASES; ph++) begin
            // Drain before touching the registers.
            s_tvalid <= 1'b0;
            while (awaited_status_q.size() != 0) @(negedge aclk);
            repeat (8) @(negedge aclk);
            case (ph)
                1: begin
                    attr_data = 8'h00;
                    vis_data  = 8'h00;
                end
                2: begin
                    attr_data = 8'h7F;
                    vis_data  = 8'h01;
                end
                3: begin
                    attr_data = $urandom_range(0, 255);
                    vis_data  = {7'($urandom_range(0, 127)), 1'b0};
                end
                4: begin
                    attr_data = $urandom_range(0, 255);
                    vis_data  = {7'($urandom_range(0, 127)), 1'b1};
                end
                default: begin
                    attr_data  = 8'hFF;
                    vis_data   = $urandom_range(0, 255);
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
            endcase
            write_reg(CFG_TEXT_ATTRIBUTE, attr_data);
            write_reg(CFG_CURSOR_ON, vis_data);
            cfg_valid <= 1'b0;

            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (k % 50 == 0) begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 10;
                        default: gap_pct = 35;
                    endcase
                end
                if (ph == 2 && k == 100)
                    hold_req = 1'b1;

                // Mostly text with controls, moves biased toward the last row and
                // column so that wraps and scrolls are frequent, reads, rare clears.
                ch   = $urandom_range(0, 255);
                tc   = $urandom_range(0, 127);
                tr   = $urandom_range(0, 31);
                pick = $urandom_range(0, 99);
                if (pick < 1) begin
                    op = OP_CLEAR;
                end else if (pick < 16) begin
                    op = OP_MOVE;
                    if ($urandom_range(0, 1) != 0)
                        tc = $urandom_range(70, 127);
                    if ($urandom_range(0, 2) != 0)
                        tr = $urandom_range(22, 31);
                end else if (pick < 40) begin
                    op = OP_READ;
                end else begin
                    op = OP_PUT;
                    case ($urandom_range(0, 19))
                        0, 1: ch = CH_BACKSPACE;
                        2, 3: ch = CH_LINE_FEED;
                        4: ch = CH_RETURN;
                        default: ;
                    endcase
                end
                send_op(op, ch, tc, tr, 1'b0, NO_STATUS);
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_status_q.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_queue.sv
sv/tcw_back.sv
sv/text_console_writer_unit.sv
tb/text_console_writer_unit_tb.sv
